/* sv/cdo_pkg.sv */
// cdo_pkg: shared types, constants and month-length function for the date offset core
// depends on nothing; imported by calendar_date_offset_core
package cdo_pkg;

  localparam int COUNT_BITS = 16;
  localparam int WORK_BITS  = (COUNT_BITS > 5) ? COUNT_BITS : 5;
  localparam int LAST_YEAR  = 9999;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_CLAMP   = 2'd2;

  localparam logic [0:0] DIR_FWD = 1'b0;
  localparam logic [0:0] DIR_BWD = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REM,
    S_CHECK,
    S_STEP
  } cdo_state_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd2: d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

/* sv/calendar_date_offset_core.sv */
// calendar_date_offset_core: moves a gregorian date forward or back by a day count
// one beat at a time; busy stays high from accept until the result strobe
// the year is split mod 100 by a seven-step subtract unit, then
// add/compare logic steps the date one month per cycle
// rst is synchronous and returns the sequencer to idle with no result pending
module calendar_date_offset_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        req_type,
  input  logic [4:0]  start_day,
  input  logic [3:0]  start_month,
  input  logic [13:0] start_year,
  input  logic [15:0] day_count,
  output logic        busy,
  output logic        done,
  output logic [4:0]  new_day,
  output logic [3:0]  new_month,
  output logic [13:0] new_year,
  output logic [1:0]  status
);
  import cdo_pkg::*;

  cdo_state_t           state, state_next;
  logic [2:0]           kcnt, kcnt_next;
  logic                 dir, dir_next;
  logic [4:0]           day, day_next;
  logic [3:0]           month, month_next;
  logic [13:0]          year, year_next;
  logic [13:0]          rem100, rem100_next;
  logic [6:0]           ymod, ymod_next;
  logic [1:0]           cent, cent_next;
  logic [WORK_BITS-1:0] rem, rem_next;
  logic                 done_next;
  logic [4:0]           out_day_next;
  logic [3:0]           out_month_next;
  logic [13:0]          out_year_next;
  logic [1:0]           out_status_next;

  logic                 leap;
  logic [4:0]           mlen;
  logic [4:0]           mlen_prev;
  logic [4:0]           avail;
  logic [13:0]          sub_val;
  logic [WORK_BITS-1:0] avail_w;
  logic [WORK_BITS-1:0] day_w;

  assign leap = (ymod == 7'd0) ? (cent == 2'd0) : (year[1:0] == 2'b00);
  assign mlen = month_len(month, leap);
  assign mlen_prev = month_len(month - 4'd1, leap);
  assign avail = mlen - day;
  assign avail_w = WORK_BITS'(avail);
  assign day_w = WORK_BITS'(day);
  assign sub_val = 14'd100 << kcnt;
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    kcnt      <= kcnt_next;
    dir       <= dir_next;
    day       <= day_next;
    month     <= month_next;
    year      <= year_next;
    rem100    <= rem100_next;
    ymod      <= ymod_next;
    cent      <= cent_next;
    rem       <= rem_next;
    new_day   <= out_day_next;
    new_month <= out_month_next;
    new_year  <= out_year_next;
    status    <= out_status_next;
  end

  always_comb begin
    state_next      = state;
    kcnt_next       = kcnt;
    dir_next        = dir;
    day_next        = day;
    month_next      = month;
    year_next       = year;
    rem100_next     = rem100;
    ymod_next       = ymod;
    cent_next       = cent;
    rem_next        = rem;
    done_next       = 1'b0;
    out_day_next    = new_day;
    out_month_next  = new_month;
    out_year_next   = new_year;
    out_status_next = status;
    case (state)
      S_IDLE: begin
        if (start) begin
          dir_next    = req_type;
          day_next    = start_day;
          month_next  = start_month;
          year_next   = start_year;
          rem100_next = start_year;
          rem_next    = WORK_BITS'(COUNT_BITS'(day_count));
          kcnt_next   = 3'd6;
          cent_next   = 2'd0;
          state_next  = S_REM;
        end
      end
      S_REM: begin
        if (rem100 >= sub_val) begin
          rem100_next = rem100 - sub_val;
          cent_next   = {cent[0], 1'b1};
        end else begin
          cent_next   = {cent[0], 1'b0};
        end
        ymod_next = rem100_next[6:0];
        kcnt_next = kcnt - 3'd1;
        if (kcnt == 3'd0) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (year == 14'd0 || year > 14'(LAST_YEAR) || month == 4'd0 || month > 4'd12 ||
            day == 5'd0 || day > mlen) begin
          out_day_next    = day;
          out_month_next  = month;
          out_year_next   = year;
          out_status_next = ST_INVALID;
          done_next       = 1'b1;
          state_next      = S_IDLE;
        end else begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (dir == DIR_FWD) begin
          if (rem <= avail_w) begin
            out_day_next    = day + 5'(rem);
            out_month_next  = month;
            out_year_next   = year;
            out_status_next = ST_OK;
            done_next       = 1'b1;
            state_next      = S_IDLE;
          end else begin
            rem_next = rem - avail_w - WORK_BITS'(1);
            day_next = 5'd1;
            if (month == 4'd12) begin
              if (year == 14'(LAST_YEAR)) begin
                out_day_next    = 5'd31;
                out_month_next  = 4'd12;
                out_year_next   = 14'(LAST_YEAR);
                out_status_next = ST_CLAMP;
                done_next       = 1'b1;
                state_next      = S_IDLE;
              end else begin
                month_next = 4'd1;
                year_next  = year + 14'd1;
                if (ymod == 7'd99) begin
                  ymod_next = 7'd0;
                  cent_next = cent + 2'd1;
                end else begin
                  ymod_next = ymod + 7'd1;
                end
              end
            end else begin
              month_next = month + 4'd1;
            end
          end
        end else begin
          if (rem < day_w) begin
            out_day_next    = day - 5'(rem);
            out_month_next  = month;
            out_year_next   = year;
            out_status_next = ST_OK;
            done_next       = 1'b1;
            state_next      = S_IDLE;
          end else begin
            rem_next = rem - day_w;
            if (month == 4'd1) begin
              if (year == 14'd1) begin
                out_day_next    = 5'd1;
                out_month_next  = 4'd1;
                out_year_next   = 14'd1;
                out_status_next = ST_CLAMP;
                done_next       = 1'b1;
                state_next      = S_IDLE;
              end else begin
                month_next = 4'd12;
                day_next   = 5'd31;
                year_next  = year - 14'd1;
                if (ymod == 7'd0) begin
                  ymod_next = 7'd99;
                  cent_next = cent - 2'd1;
                end else begin
                  ymod_next = ymod - 7'd1;
                end
              end
            end else begin
              month_next = month - 4'd1;
              day_next   = mlen_prev;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_clamp_bound: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_CLAMP |->
      (new_year == 14'(LAST_YEAR) && new_month == 4'd12 && new_day == 5'd31) ||
      (new_year == 14'd1 && new_month == 4'd1 && new_day == 5'd1))
    else $error("clamped result not at a bound");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status == ST_OK || status == ST_INVALID || status == ST_CLAMP)
    else $error("bad status code");

endmodule
